// ----- design/transaction_id_tracker_assert.svh -----
// assertion macros used by tidt_ctrl of the transaction id tracker rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef TRANSACTION_ID_TRACKER_ASSERT_SVH
`define TRANSACTION_ID_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define TIDT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TIDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TIDT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define TIDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/tidt_pkg.sv -----
// types, codes and helpers for the transaction id tracker
// no dependencies; imported by every rtl module of the block
package tidt_pkg;

    localparam int DEF_ENTRY_COUNT = 8;

    localparam logic [7:0] ID_FIRST = 8'd1;
    localparam logic [7:0] ID_MAX   = 8'd255;
    localparam logic [7:0] ID_NONE  = 8'd0;

    localparam logic [7:0] PHASE_COMPLETED = 8'd1;
    localparam logic [7:0] PHASE_REJECTED  = 8'd2;
    localparam logic [7:0] PHASE_FAILED    = 8'd3;

    typedef enum logic [1:0] {
        OP_RESERVE = 2'd0,
        OP_MARK    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_QUERY   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_SCAN,
        ST_HOLD
    } t_state;

    // scan token passed from cell to cell
    typedef struct packed {
        logic       active;
        t_op        op;
        logic [7:0] tid;
        logic [7:0] cmd;
        logic [2:0] kind;
        logic [7:0] phase;
        logic       commit;
        logic       hit;
        logic       free;
    } t_tok;

    function automatic logic [7:0] id_advance(input logic [7:0] id);
        return (id == ID_MAX) ? ID_FIRST : id + 8'd1;
    endfunction

endpackage

// ----- design/tidt_cell.sv -----
// one table entry of the transaction id tracker and its stage of the scan chain
// depends on tidt_pkg
module tidt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tidt_pkg::t_tok i_tok,
    output tidt_pkg::t_tok o_tok
);
    import tidt_pkg::*;

    logic       r_valid, n_valid;
    logic [7:0] r_id, n_id;
    logic [2:0] r_kind, n_kind;
    logic [7:0] r_cmd, n_cmd;
    t_tok       r_tok, n_tok;
    logic       id_hit;

    always_comb begin
        n_tok   = i_tok;
        n_valid = r_valid;
        n_id    = r_id;
        n_kind  = r_kind;
        n_cmd   = r_cmd;
        id_hit  = r_valid && (r_id == i_tok.tid);
        if (i_tok.active) begin
            case (i_tok.op)
                OP_RESERVE: begin
                    if (i_tok.commit) begin
                        if (!r_valid && !i_tok.hit) begin
                            n_valid   = 1'b1;
                            n_id      = i_tok.tid;
                            n_kind    = i_tok.kind;
                            n_cmd     = i_tok.cmd;
                            n_tok.hit = 1'b1;
                        end
                    end else begin
                        if (id_hit) n_tok.hit = 1'b1;
                        if (!r_valid) n_tok.free = 1'b1;
                    end
                end
                OP_MARK: begin
                    if (!i_tok.hit && id_hit && (r_cmd == i_tok.cmd)) begin
                        n_tok.hit = 1'b1;
                        if (i_tok.phase == PHASE_COMPLETED || i_tok.phase == PHASE_REJECTED ||
                            i_tok.phase == PHASE_FAILED) begin
                            n_valid = 1'b0;
                        end
                    end
                end
                OP_RELEASE: begin
                    if (!i_tok.hit && id_hit) begin
                        n_tok.hit = 1'b1;
                        n_valid   = 1'b0;
                    end
                end
                OP_QUERY: begin
                    if (id_hit && (i_tok.tid != ID_NONE)) n_tok.hit = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
        r_id   <= n_id;
        r_kind <= n_kind;
        r_cmd  <= n_cmd;
    end

    assign o_tok = r_tok;

endmodule

// ----- design/tidt_ctrl.sv -----
// request sequencer of the transaction id tracker: launches scans, steps ids, holds the result
// depends on tidt_pkg and transaction_id_tracker_assert.svh
module tidt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [1:0]     i_op,
    input  logic [7:0]     i_transaction_id,
    input  logic [7:0]     i_command,
    input  logic [2:0]     i_kind,
    input  logic [7:0]     i_phase,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_ok,
    output logic [7:0]     o_assigned_id,
    output tidt_pkg::t_tok o_tok,
    input  tidt_pkg::t_tok i_tok
);
    import tidt_pkg::*;

    `include "transaction_id_tracker_assert.svh"

    t_state     r_state, n_state;
    t_op        r_op;
    logic [7:0] r_tid;
    logic [7:0] r_cmd;
    logic [2:0] r_kind;
    logic [7:0] r_phase;
    logic       r_commit;
    logic [7:0] r_next_id;
    logic       r_res_ok;
    logic [7:0] r_res_id;
    logic       r_out_valid;
    logic       r_ok;
    logic [7:0] r_assigned;

    logic       accept;
    logic       done;
    logic       relaunch;
    logic       finish;
    logic       fin_ok;
    logic [7:0] fin_id;
    logic       out_free;
    logic       load_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_LAUNCH;
            ST_LAUNCH: n_state = ST_SCAN;
            ST_SCAN: begin
                if (done) begin
                    if (relaunch) n_state = ST_LAUNCH;
                    else if (out_free) n_state = ST_IDLE;
                    else n_state = ST_HOLD;
                end
            end
            ST_HOLD:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs and decisions
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        accept     = o_in_ready && i_in_valid;
        out_free   = !r_out_valid || i_out_ready;
        done       = (r_state == ST_SCAN) && i_tok.active;
        relaunch   = 1'b0;
        fin_ok     = i_tok.hit;
        fin_id     = ID_NONE;
        if (r_op == OP_RESERVE) begin
            if (i_tok.commit) begin
                fin_id = i_tok.tid;
            end else if (!i_tok.free) begin
                fin_ok = 1'b0;
            end else begin
                relaunch = 1'b1;
            end
        end
        finish   = done && !relaunch;
        load_out = (finish && out_free) || ((r_state == ST_HOLD) && out_free);

        o_tok        = '0;
        o_tok.active = (r_state == ST_LAUNCH);
        o_tok.op     = r_op;
        o_tok.tid    = r_tid;
        o_tok.cmd    = r_cmd;
        o_tok.kind   = r_kind;
        o_tok.phase  = r_phase;
        o_tok.commit = r_commit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_commit    <= 1'b0;
            r_next_id   <= ID_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_commit <= 1'b0;
            end else if (done && relaunch) begin
                // a pending candidate moves on, a free one gets claimed next
                r_commit  <= !i_tok.hit;
                r_next_id <= id_advance(r_tid);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_op    <= t_op'(i_op);
            r_tid   <= (t_op'(i_op) == OP_RESERVE) ? r_next_id : i_transaction_id;
            r_cmd   <= i_command;
            r_kind  <= i_kind;
            r_phase <= i_phase;
        end else if (done && relaunch && i_tok.hit) begin
            r_tid <= id_advance(r_tid);
        end
        if (finish) begin
            r_res_ok <= fin_ok;
            r_res_id <= fin_id;
        end
        if (load_out) begin
            r_ok       <= (r_state == ST_HOLD) ? r_res_ok : fin_ok;
            r_assigned <= (r_state == ST_HOLD) ? r_res_id : fin_id;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_assigned_id = r_assigned;

    `TIDT_ASSERT_IMPLY(a_tok_only_in_scan, i_clk, i_rst_n, i_tok.active, r_state == ST_SCAN)
    `TIDT_ASSERT_IMPLY(a_next_id_nonzero, i_clk, i_rst_n, 1'b1, r_next_id != ID_NONE)
    `TIDT_ASSERT_IMPLY(a_commit_claims, i_clk, i_rst_n, done && i_tok.commit, i_tok.hit)
    `TIDT_ASSERT_NEXT(a_full_keeps_id, i_clk, i_rst_n, done && (r_op == OP_RESERVE) && !i_tok.commit && !i_tok.free, r_next_id == $past(r_next_id))

endmodule

// ----- design/transaction_id_tracker.sv -----
// Outstanding transaction table for uplink commands.
// Input channel (i_in_valid / o_in_ready) carries one request word: op, transaction id,
// command, kind and phase. Output channel (o_out_valid / i_out_ready) returns one word
// per request: o_ok and o_assigned_id (zero for everything but a successful reserve).
// The table is a chain of ENTRY_COUNT cells; a request runs as a token down the chain,
// one cell per cycle. Mark result, release and query take one pass. A reserve first
// scans for a free entry and checks the candidate id, one pass per candidate tried,
// then takes one more pass to claim the entry, skipping at most ENTRY_COUNT - 1
// pending ids. A full table fails after a single pass.
// One request is worked on at a time; the next is accepted as soon as the result is
// in the output register, even while the receiver stalls it.
// Reset empties the table at once and restarts the id counter at 1.
module transaction_id_tracker #(
    parameter int ENTRY_COUNT = tidt_pkg::DEF_ENTRY_COUNT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_transaction_id,
    input  logic [7:0] i_command,
    input  logic [2:0] i_kind,
    input  logic [7:0] i_phase,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_ok,
    output logic [7:0] o_assigned_id
);
    import tidt_pkg::*;

    t_tok w_tok [ENTRY_COUNT+1];

    tidt_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_transaction_id (i_transaction_id),
        .i_command        (i_command),
        .i_kind           (i_kind),
        .i_phase          (i_phase),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_ok             (o_ok),
        .o_assigned_id    (o_assigned_id),
        .o_tok            (w_tok[0]),
        .i_tok            (w_tok[ENTRY_COUNT])
    );

    for (genvar g = 0; g < ENTRY_COUNT; g++) begin : g_cell
        tidt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

endmodule

// ----- verif/tidt_table_checker.sv -----
// checker for the transaction id tracker: watches both handshake channels,
// predicts each result from its own copy of the table and compares in order
// depends on tidt_pkg for the op codes, id limits and phase codes
module tidt_table_checker #(
    parameter int ENTRY_COUNT = tidt_pkg::DEF_ENTRY_COUNT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_transaction_id,
    input  logic [7:0] i_command,
    input  logic [2:0] i_kind,
    input  logic [7:0] i_phase,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_ok,
    input  logic [7:0] i_assigned_id,
    output int         o_outstanding,
    output int         o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;
    import tidt_pkg::*;

    typedef struct packed {
        logic       ok;
        logic [7:0] assigned;
    } t_reply;

    logic       entry_busy [ENTRY_COUNT];
    logic [7:0] entry_tid  [ENTRY_COUNT];
    logic [2:0] entry_kind [ENTRY_COUNT];
    logic [7:0] entry_cmd  [ENTRY_COUNT];
    logic [7:0] id_counter;

    t_reply expected_replies[$];
    int     mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic bit id_held(input logic [7:0] tid);
        if (tid == ID_NONE) begin
            return 1'b0;
        end
        for (int e = 0; e < ENTRY_COUNT; e++) begin
            if (entry_busy[e] && entry_tid[e] == tid) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic clear_table();
        for (int e = 0; e < ENTRY_COUNT; e++) begin
            entry_busy[e] = 1'b0;
            entry_tid[e]  = '0;
            entry_kind[e] = '0;
            entry_cmd[e]  = '0;
        end
        id_counter = ID_FIRST;
    endtask

    task automatic predict_request(input t_op op, input logic [7:0] tid, input logic [7:0] cmd,
                                   input logic [2:0] kind, input logic [7:0] phase,
                                   output t_reply reply);
        int         open_slot;
        int         hit_entry;
        logic [7:0] cand;
        reply = '0;
        open_slot = -1;
        hit_entry = -1;
        case (op)
            OP_RESERVE: begin
                for (int e = ENTRY_COUNT - 1; e >= 0; e--) begin
                    if (!entry_busy[e]) begin
                        open_slot = e;
                    end
                end
                if (open_slot >= 0) begin
                    for (int tries = 0; tries < 255 && !reply.ok; tries++) begin
                        cand = id_counter;
                        id_counter = (id_counter == ID_MAX) ? ID_FIRST : id_counter + 8'd1;
                        if (!id_held(cand)) begin
                            entry_busy[open_slot] = 1'b1;
                            entry_tid[open_slot]  = cand;
                            entry_kind[open_slot] = kind;
                            entry_cmd[open_slot]  = cmd;
                            reply.ok = 1'b1;
                            reply.assigned = cand;
                        end
                    end
                end
            end
            OP_MARK: begin
                for (int e = ENTRY_COUNT - 1; e >= 0; e--) begin
                    if (entry_busy[e] && entry_tid[e] == tid && entry_cmd[e] == cmd) begin
                        hit_entry = e;
                    end
                end
                if (hit_entry >= 0) begin
                    if (phase == PHASE_COMPLETED || phase == PHASE_REJECTED ||
                        phase == PHASE_FAILED) begin
                        entry_busy[hit_entry] = 1'b0;
                    end
                    reply.ok = 1'b1;
                end
            end
            OP_RELEASE: begin
                for (int e = ENTRY_COUNT - 1; e >= 0; e--) begin
                    if (entry_busy[e] && entry_tid[e] == tid) begin
                        hit_entry = e;
                    end
                end
                if (hit_entry >= 0) begin
                    entry_busy[hit_entry] = 1'b0;
                    reply.ok = 1'b1;
                end
            end
            default: begin
                reply.ok = id_held(tid);
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            clear_table();
            expected_replies.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_request(t_op'(i_op), i_transaction_id, i_command, i_kind, i_phase, want);
                expected_replies.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("unrequested word, ok", i_ok, 0);
                end else begin
                    want = expected_replies.pop_front();
                    if (i_ok !== want.ok) begin
                        report_mismatch("ok", i_ok, want.ok);
                    end
                    if (i_assigned_id !== want.assigned) begin
                        report_mismatch("assigned_id", i_assigned_id, want.assigned);
                    end
                end
            end
        end
        o_outstanding <= expected_replies.size();
    end

endmodule

// ----- verif/tb.sv -----
// top of the transaction id tracker testbench: clock, reset, request stimulus
// and output back-pressure; the checker in tidt_table_checker does the comparing
// depends on tidt_pkg, transaction_id_tracker and tidt_table_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tidt_pkg::*;

    localparam int LONG_STALL = 300;
    localparam int PHASE_ITEMS = 650;

    typedef struct {
        logic [7:0] tid;
        logic [7:0] cmd;
    } t_live_entry;

    typedef struct {
        t_op        op;
        logic [7:0] cmd;
    } t_issued;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] req_op = '0;
    logic [7:0] req_tid = '0;
    logic [7:0] req_cmd = '0;
    logic [2:0] req_kind = '0;
    logic [7:0] req_phase = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       ok;
    logic [7:0] assigned_id;
    int         outstanding;
    int         mismatches;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        stall_toggle = 1'b0;
    logic        stall_seen = 1'b0;
    int          stall_left = 0;
    int          sent_count = 0;
    t_live_entry live_ids[$];
    t_issued     issued_reqs[$];

    transaction_id_tracker #(
        .ENTRY_COUNT(DEF_ENTRY_COUNT)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_op            (req_op),
        .i_transaction_id(req_tid),
        .i_command       (req_cmd),
        .i_kind          (req_kind),
        .i_phase         (req_phase),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_ok            (ok),
        .o_assigned_id   (assigned_id)
    );

    tidt_table_checker #(
        .ENTRY_COUNT(DEF_ENTRY_COUNT)
    ) i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_op            (req_op),
        .i_transaction_id(req_tid),
        .i_command       (req_cmd),
        .i_kind          (req_kind),
        .i_phase         (req_phase),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_ok            (ok),
        .i_assigned_id   (assigned_id),
        .o_outstanding   (outstanding),
        .o_mismatches    (mismatches)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver: random idling, plus a long hold-off on each toggle request
    always @(posedge clk) begin
        if (stall_toggle != stall_seen) begin
            stall_seen <= stall_toggle;
            stall_left <= LONG_STALL;
            out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // collect handed-out ids so later requests can target live entries
    always @(posedge clk) begin
        t_issued req;
        if (rst_n && out_valid && out_ready && issued_reqs.size() != 0) begin
            req = issued_reqs.pop_front();
            if (req.op == OP_RESERVE && ok && assigned_id != ID_NONE) begin
                live_ids.push_back('{assigned_id, req.cmd});
            end
            if (live_ids.size() > 16) begin
                live_ids.delete(2);
            end
        end
    end

    task automatic send_request(input t_op op, input logic [7:0] tid, input logic [7:0] cmd,
                                input logic [2:0] kind, input logic [7:0] phase);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_op <= op;
        req_tid <= tid;
        req_cmd <= cmd;
        req_kind <= kind;
        req_phase <= phase;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        issued_reqs.push_back('{op, cmd});
        sent_count++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0) begin
            @(posedge clk);
        end
    endtask

    // oldest two entries are mostly left alone so they stay pending across id wraps
    function automatic int pick_live();
        int n;
        n = live_ids.size();
        if (n == 0) begin
            return -1;
        end
        if (n > 2 && $urandom_range(49) != 0) begin
            return $urandom_range(n - 1, 2);
        end
        return $urandom_range(n - 1, 0);
    endfunction

    function automatic logic [7:0] random_phase();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4) begin
            return 8'($urandom_range(PHASE_FAILED, PHASE_COMPLETED));
        end else if (sel < 7) begin
            return 8'd0;
        end
        return 8'($urandom);
    endfunction

    task automatic send_random_request();
        int         sel;
        int         idx;
        logic [7:0] tid;
        logic [7:0] cmd;
        logic [7:0] phase;
        logic [2:0] kind;
        sel = $urandom_range(99);
        idx = pick_live();
        tid = 8'($urandom);
        cmd = 8'($urandom);
        kind = 3'($urandom);
        phase = random_phase();
        if (sel < 36) begin
            send_request(OP_RESERVE, tid, cmd, kind, phase);
        end else if (sel < 66) begin
            if (idx >= 0 && $urandom_range(9) < 8) begin
                tid = live_ids[idx].tid;
                cmd = ($urandom_range(9) == 0) ? (live_ids[idx].cmd ^ 8'h01) : live_ids[idx].cmd;
                if (cmd == live_ids[idx].cmd && phase >= PHASE_COMPLETED &&
                    phase <= PHASE_FAILED) begin
                    live_ids.delete(idx);
                end
            end
            send_request(OP_MARK, tid, cmd, kind, phase);
        end else if (sel < 81) begin
            if (idx >= 0 && $urandom_range(19) < 17) begin
                tid = live_ids[idx].tid;
                live_ids.delete(idx);
            end
            send_request(OP_RELEASE, tid, cmd, kind, phase);
        end else begin
            if (idx >= 0 && $urandom_range(1) == 0) begin
                tid = live_ids[idx].tid;
            end else if ($urandom_range(9) == 0) begin
                tid = ID_NONE;
            end
            send_request(OP_QUERY, tid, cmd, kind, phase);
        end
    endtask

    task automatic run_phase(input int items);
        for (int n = 0; n < items; n++) begin
            send_random_request();
            if (n == items / 2) begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: id zero, wrong command, non-terminal phases, full table
        send_request(OP_QUERY, ID_NONE, 8'h00, 3'd0, 8'h00);
        send_request(OP_QUERY, ID_MAX, 8'h00, 3'd0, 8'h00);
        send_request(OP_RESERVE, 8'h00, 8'h00, 3'd0, 8'h00);
        send_request(OP_RESERVE, 8'hff, 8'hff, 3'd7, 8'hff);
        send_request(OP_QUERY, 8'd1, 8'h00, 3'd0, 8'h00);
        send_request(OP_MARK, 8'd1, 8'h05, 3'd0, PHASE_COMPLETED);
        send_request(OP_MARK, 8'd1, 8'h00, 3'd0, 8'd0);
        send_request(OP_MARK, 8'd1, 8'h00, 3'd0, 8'd200);
        send_request(OP_MARK, 8'd1, 8'h00, 3'd0, PHASE_COMPLETED);
        send_request(OP_QUERY, 8'd1, 8'h00, 3'd0, 8'h00);
        send_request(OP_RELEASE, 8'd2, 8'h00, 3'd0, 8'h00);
        send_request(OP_RELEASE, 8'd2, 8'h00, 3'd0, 8'h00);
        send_request(OP_RELEASE, ID_NONE, 8'h00, 3'd0, 8'h00);
        send_request(OP_MARK, ID_NONE, 8'h00, 3'd0, PHASE_REJECTED);
        for (int n = 0; n < DEF_ENTRY_COUNT; n++) begin
            send_request(OP_RESERVE, 8'h00, 8'h30 + 8'(n), n[2:0], 8'h00);
        end
        send_request(OP_RESERVE, 8'h00, 8'haa, 3'd4, 8'h00);
        send_request(OP_MARK, 8'd3, 8'h30, 3'd0, PHASE_REJECTED);
        send_request(OP_MARK, 8'd4, 8'h31, 3'd0, PHASE_FAILED);
        send_request(OP_QUERY, 8'hff, 8'hff, 3'd7, 8'hff);
        wait_drained();

        send_idle_pct = 17;
        recv_idle_pct <= 84;
        run_phase(PHASE_ITEMS);

        send_idle_pct = 84;
        recv_idle_pct <= 17;
        run_phase(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        stall_toggle <= ~stall_toggle;
        run_phase(PHASE_ITEMS);

        repeat (100) @(posedge clk);
        $display("covered %0d requests: directed table cases, id wrap with pending ids,",
                 sent_count);
        $display("full table, three idle profiles and a long output hold-off");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
